/* hdl/text_console_writer_defines.svh */
// ----------------------------------------------------------------------------
// Text console writer: assertion macros
// Shared assertion forms for the console writer modules. The using module
// provides aclk and aresetn.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication
`define TCW_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("text console writer: assertion failed");

// Next-cycle implication
`define TCW_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("text console writer: assertion failed");

`endif

/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console writer package
// Grid geometry, opcodes, character constants and the shared payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int ROWS       = 25;
    localparam int COLS       = 80;
    localparam int CELLS      = ROWS * COLS;
    localparam int BODY_CELLS = CELLS - COLS;

    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLS);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_PUT_AT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [7:0] NEWLINE_CODE       = 8'd10;
    localparam logic [7:0] SPACE_CODE         = 8'd32;
    localparam logic [7:0] CLEAR_ATTR         = 8'h0f;
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'h0f;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [4:0] row;
        logic [6:0] col;
    } tcw_in_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [7:0]          cell_char;
        logic [7:0]          cell_attr;
        logic                scrolled;
    } tcw_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [ROW_W-1:0]  next_row;
        logic [COL_W-1:0]  next_col;
        logic              wrap;
    } tcw_pos_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              re;
        logic [ADDR_W-1:0] rd_addr;
    } tcw_mem_req_t;

endpackage

`default_nettype wire

/* hdl/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// Text console writer cell RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              re,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/tcw_pos_unit.sv */
// ----------------------------------------------------------------------------
// Text console writer position unit
// Shared row/column to cell index unit with the cursor advance rule.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_pos_unit (
    input  logic [tcw_pkg::ROW_W-1:0] row,
    input  logic [tcw_pkg::COL_W-1:0] col,
    input  logic                      newline,
    output tcw_pkg::tcw_pos_t         pos
);

    import tcw_pkg::*;

    logic adv_row;
    logic last_row;

    always_comb begin
        adv_row      = newline || (col == COL_W'(COLS - 1));
        last_row     = (row == ROW_W'(ROWS - 1));
        pos.idx      = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
        pos.next_col = adv_row ? '0 : col + COL_W'(1);
        pos.next_row = (adv_row && !last_row) ? row + ROW_W'(1) : row;
        pos.wrap     = adv_row && last_row;
    end

endmodule

`default_nettype wire

/* hdl/tcw_seq.sv */
// ----------------------------------------------------------------------------
// Text console writer sequencer
// Steps each request through address, memory access, scroll and clear sweeps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  tcw_pkg::tcw_in_t              in_data,
    output logic                          in_ready,
    input  logic [7:0]                    default_attr,
    output tcw_pkg::tcw_out_t             res,
    output logic                          res_valid,
    input  logic                          res_free,
    output tcw_pkg::tcw_mem_req_t         mem_req,
    input  logic [tcw_pkg::CELL_W-1:0]    mem_rd_data
);

    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ADDR   = 3'd2;
    localparam logic [2:0] ST_EXEC   = 3'd3;
    localparam logic [2:0] ST_RDATA  = 3'd4;
    localparam logic [2:0] ST_SCROLL = 3'd5;
    localparam logic [2:0] ST_CLEAR  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic              scroll_reg, scroll_next;

    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0]        op_reg, op_next;
    logic [7:0]        ch_reg, ch_next;
    logic [7:0]        attr_reg, attr_next;
    logic [ROW_W-1:0]  tgt_row_reg, tgt_row_next;
    logic [COL_W-1:0]  tgt_col_reg, tgt_col_next;
    logic              range_ok_reg, range_ok_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CELL_W-1:0] rdata_reg, rdata_next;

    logic [ROW_W-1:0]  pu_row;
    logic [COL_W-1:0]  pu_col;
    tcw_pos_t          pos;
    logic [CNT_W-1:0]  src_sum;
    logic              item_in_range;

    tcw_pos_unit u_pos (
        .row     (pu_row),
        .col     (pu_col),
        .newline (ch_reg == NEWLINE_CODE),
        .pos     (pos)
    );

    always_comb begin
        pu_row = (state_reg == ST_DONE) ? cur_row_reg : tgt_row_reg;
        pu_col = (state_reg == ST_DONE) ? cur_col_reg : tgt_col_reg;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        scroll_next   = scroll_reg;
        wr_ptr_next   = wr_ptr_reg;
        op_next       = op_reg;
        ch_next       = ch_reg;
        attr_next     = attr_reg;
        tgt_row_next  = tgt_row_reg;
        tgt_col_next  = tgt_col_reg;
        range_ok_next = range_ok_reg;
        addr_next     = addr_reg;
        rdata_next    = rdata_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_req       = '0;
        src_sum       = cnt_reg + CNT_W'(COLS);
        item_in_range = (int'(in_data.row) < ROWS) && (int'(in_data.col) < COLS);

        case (state_reg)
            ST_INIT: begin
                mem_req.we      = 1'b1;
                mem_req.wr_addr = cnt_reg[ADDR_W-1:0];
                cnt_next        = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next   = in_data.opcode;
                    ch_next   = in_data.char_code;
                    attr_next = (in_data.attribute == 8'd0) ? default_attr
                                                            : in_data.attribute;
                    if (in_data.opcode == OP_PUT) begin
                        tgt_row_next  = cur_row_reg;
                        tgt_col_next  = cur_col_reg;
                        range_ok_next = 1'b1;
                    end else begin
                        tgt_row_next  = ROW_W'(in_data.row);
                        tgt_col_next  = COL_W'(in_data.col);
                        range_ok_next = item_in_range;
                    end
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                scroll_next = 1'b0;
                rdata_next  = '0;
                addr_next   = pos.idx;
                cnt_next    = '0;
                if (op_reg == OP_CLEAR) begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                    scroll_next  = 1'b1;
                    state_next   = ST_CLEAR;
                end else if (!range_ok_reg) begin
                    state_next = ST_DONE;
                end else if (op_reg == OP_READ) begin
                    state_next = ST_EXEC;
                end else begin
                    cur_row_next = pos.next_row;
                    cur_col_next = pos.next_col;
                    scroll_next  = pos.wrap;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_READ) begin
                    mem_req.re      = 1'b1;
                    mem_req.rd_addr = addr_reg;
                    state_next      = ST_RDATA;
                end else begin
                    mem_req.we      = (ch_reg != NEWLINE_CODE);
                    mem_req.wr_addr = addr_reg;
                    mem_req.wr_data = {attr_reg, ch_reg};
                    state_next      = scroll_reg ? ST_SCROLL : ST_DONE;
                end
            end
            ST_RDATA: begin
                rdata_next = mem_rd_data;
                state_next = ST_DONE;
            end
            ST_SCROLL: begin
                // read one row ahead, write the cell fetched last cycle
                mem_req.re      = (cnt_reg < CNT_W'(BODY_CELLS));
                mem_req.rd_addr = src_sum[ADDR_W-1:0];
                mem_req.we      = (cnt_reg != '0);
                mem_req.wr_addr = wr_ptr_reg;
                mem_req.wr_data = (wr_ptr_reg < ADDR_W'(BODY_CELLS)) ? mem_rd_data : '0;
                wr_ptr_next     = cnt_reg[ADDR_W-1:0];
                cnt_next        = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS)) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR: begin
                mem_req.we      = 1'b1;
                mem_req.wr_addr = cnt_reg[ADDR_W-1:0];
                mem_req.wr_data = (cnt_reg < CNT_W'(BODY_CELLS)) ? {CLEAR_ATTR, SPACE_CODE}
                                                                 : '0;
                cnt_next        = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        res.cursor_cell = CURSOR_W'(pos.idx);
        res.cell_char   = rdata_reg[7:0];
        res.cell_attr   = rdata_reg[15:8];
        res.scrolled    = scroll_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            scroll_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            scroll_reg  <= scroll_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_ptr_reg   <= wr_ptr_next;
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        attr_reg     <= attr_next;
        tgt_row_reg  <= tgt_row_next;
        tgt_col_reg  <= tgt_col_next;
        range_ok_reg <= range_ok_next;
        addr_reg     <= addr_next;
        rdata_reg    <= rdata_next;
    end

    `TCW_ASSERT_IMP(a_cursor_in_grid, 1'b1, (int'(cur_row_reg) < ROWS) && (int'(cur_col_reg) < COLS))
    `TCW_ASSERT_IMP(a_idle_no_write, state_reg == ST_IDLE, !mem_req.we)
    `TCW_ASSERT_IMP(a_scroll_lag, (state_reg == ST_SCROLL) && (cnt_reg != '0), wr_ptr_reg == ADDR_W'(cnt_reg - CNT_W'(1)))
    `TCW_ASSERT_NXT(a_done_release, (state_reg == ST_DONE) && res_free, state_reg == ST_IDLE)
    `TCW_ASSERT_NXT(a_clear_home, (state_reg == ST_CLEAR) && (cnt_reg == CNT_W'(CELLS - 1)), (cur_row_reg == '0) && (cur_col_reg == '0) && scroll_reg)

endmodule

`default_nettype wire

/* hdl/text_console_writer.sv */
// A text console of 25 rows by 80 columns with a cursor. A plain or positioned
// put steps through the accept, address, write and result states, and its
// result is loaded into the output register from the result state; a read
// steps through accept, address, read and read data before the result, one
// state more for the registered RAM read. A positioned put or read outside the
// grid goes from address straight to result. A put that runs past the last cell
// adds a scroll sweep over the grid, and a clear walks all 2000 cells. These
// steps follow from the single-write, single-read cell RAM that every step goes
// through; the result state holds while the output register is still full.
// After reset the block zeroes every RAM cell with s_ready low; writes to the
// default attribute are taken throughout. A result may wait in the output
// register while the next request is accepted.
// ----------------------------------------------------------------------------
// Text console writer top level
// Request and result channels, default attribute register, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcw_pkg::tcw_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcw_pkg::tcw_out_t  m_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data
);

    import tcw_pkg::*;

    logic [7:0]   default_attr_reg, default_attr_next;
    logic         m_valid_reg, m_valid_next;
    tcw_out_t     m_data_reg, m_data_next;

    tcw_out_t     res;
    logic         res_valid;
    logic         res_free;
    logic         load;
    tcw_mem_req_t mem_req;
    logic [CELL_W-1:0] mem_rd_data;

    tcw_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_data      (s_data),
        .in_ready     (s_ready),
        .default_attr (default_attr_reg),
        .res          (res),
        .res_valid    (res_valid),
        .res_free     (res_free),
        .mem_req      (mem_req),
        .mem_rd_data  (mem_rd_data)
    );

    tcw_cell_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_req.we),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .re      (mem_req.re),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        res_free          = !m_valid_reg || m_ready;
        load              = res_valid && res_free;
        default_attr_next = cfg_wr_en ? cfg_wr_data : default_attr_reg;
        m_data_next       = load ? res : m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_attr_reg <= DEFAULT_ATTR_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            default_attr_reg <= default_attr_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* tb/text_console_writer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the request and result channels and the default attribute port,
// keeps its own copy of the cell grid and cursor, predicts one result per
// accepted request and compares results field by field, oldest first.
// ----------------------------------------------------------------------------

module text_console_writer_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  tcw_pkg::tcw_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  tcw_pkg::tcw_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    output int                failures,
    output int                results_pending
);

    import tcw_pkg::*;

    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cursor_pos;
    logic [7:0]        default_attr;
    tcw_out_t          expected_results [$];
    tcw_out_t          want;
    int                mismatch_count = 0;

    // Write one character (or take a newline) at pos, scroll when past the end
    function automatic bit put_char(int unsigned pos, logic [7:0] ch, logic [7:0] attr);
        int unsigned nxt;
        int          i;
        bit          wrapped;
        wrapped = 1'b0;
        if (ch == NEWLINE_CODE) begin
            nxt = (pos / COLS) * COLS + COLS;
        end else begin
            screen[pos] = {attr, ch};
            nxt = pos + 1;
        end
        if (nxt >= CELLS) begin
            for (i = 0; i < BODY_CELLS; i++) screen[i] = screen[i + COLS];
            for (i = BODY_CELLS; i < CELLS; i++) screen[i] = '0;
            nxt -= COLS;
            wrapped = 1'b1;
        end
        cursor_pos = nxt;
        return wrapped;
    endfunction

    function automatic tcw_out_t console_step(tcw_in_t req);
        tcw_out_t    res;
        logic [7:0]  attr;
        bit          fits;
        int unsigned cell_idx;
        int          i;
        res      = '0;
        attr     = (req.attribute == 8'd0) ? default_attr : req.attribute;
        fits     = (req.row < ROWS) && (req.col < COLS);
        cell_idx = req.row * COLS + req.col;
        case (req.opcode)
            OP_PUT: begin
                if (cursor_pos >= CELLS) cursor_pos = 0;
                res.scrolled = put_char(cursor_pos, req.char_code, attr);
            end
            OP_PUT_AT: begin
                if (fits) res.scrolled = put_char(cell_idx, req.char_code, attr);
            end
            OP_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    if (put_char(i, SPACE_CODE, CLEAR_ATTR)) res.scrolled = 1'b1;
                cursor_pos = 0;
            end
            default: begin
                if (fits) {res.cell_attr, res.cell_char} = screen[cell_idx];
            end
        endcase
        res.cursor_cell = cursor_pos[CURSOR_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (screen[i]) screen[i] = '0;
            cursor_pos   = 0;
            default_attr = DEFAULT_ATTR_RESET;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, got cursor %0d char %0d attr %0d scrolled %0d",
                             $time, m_data.cursor_cell, m_data.cell_char, m_data.cell_attr,
                             m_data.scrolled);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("cursor_cell", 16'(want.cursor_cell), 16'(m_data.cursor_cell));
                    check_field("cell_char", 16'(want.cell_char), 16'(m_data.cell_char));
                    check_field("cell_attr", 16'(want.cell_attr), 16'(m_data.cell_attr));
                    check_field("scrolled", 16'(want.scrolled), 16'(m_data.scrolled));
                end
            end
            if (s_valid && s_ready) expected_results.push_back(console_step(s_data));
            if (cfg_wr_en) default_attr = cfg_wr_data;
        end
        failures        <= mismatch_count;
        results_pending <= expected_results.size();
    end

endmodule

/* tb/text_console_writer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Directed requests over the grid edges, scrolls, newlines, clears and
// out-of-range positions, then random phases with sender gaps, receiver
// stalls, a long receiver hold-off and a full drain, each under its own
// default attribute. A separate checker predicts and compares all results.
// ----------------------------------------------------------------------------

module text_console_writer_tb;
    import tcw_pkg::*;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    tcw_in_t    s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    tcw_out_t   m_data;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    int failures;
    int results_pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 4200;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    text_console_writer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    text_console_writer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .failures        (failures),
        .results_pending (results_pending)
    );

    // Result side: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_ready    <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic tcw_in_t make_request(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                             logic [4:0] row, logic [6:0] col);
        tcw_in_t req;
        req.opcode    = op;
        req.char_code = ch;
        req.attribute = attr;
        req.row       = row;
        req.col       = col;
        return req;
    endfunction

    function automatic tcw_in_t random_request();
        tcw_in_t req;
        int      pick;
        req.char_code = ($urandom_range(11) == 0) ? NEWLINE_CODE : 8'($urandom_range(255));
        req.attribute = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        req.row       = 5'($urandom_range(31));
        req.col       = 7'($urandom_range(127));
        pick          = $urandom_range(99);
        if (pick < 2)       req.opcode = OP_CLEAR;
        else if (pick < 42) req.opcode = OP_PUT;
        else if (pick < 70) req.opcode = OP_PUT_AT;
        else                req.opcode = OP_READ;
        if ((req.opcode == OP_PUT_AT || req.opcode == OP_READ) && $urandom_range(9) != 0) begin
            // bias towards the bottom right corner to provoke scrolls
            if ($urandom_range(5) == 0) begin
                req.row = 5'(ROWS - 1);
                req.col = 7'($urandom_range(COLS - 1, COLS - 8));
            end else begin
                req.row = 5'($urandom_range(ROWS - 1));
                req.col = 7'($urandom_range(COLS - 1));
            end
        end
        return req;
    endfunction

    task automatic send_request(input tcw_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    task automatic write_default_attr(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int idle, input int stall,
                             input logic [7:0] attr, input int hold_at, input int pause_at);
        int i;
        write_default_attr(attr);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (i = 0; i < n_items; i++) begin
            if (i == hold_at) hold_requests <= hold_requests + 1;
            if (i == pause_at) wait_drained();
            send_request(random_request());
        end
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        write_default_attr(8'd0);

        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd0,  7'd0));
        send_request(make_request(OP_PUT,    8'h41,  8'd0,   5'd0,  7'd0));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd0,  7'd0));
        send_request(make_request(OP_PUT_AT, 8'hff,  8'hff,  5'd24, 7'd79));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd23, 7'd79));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd24, 7'd0));
        send_request(make_request(OP_PUT,    NEWLINE_CODE, 8'h12, 5'd31, 7'd127));
        send_request(make_request(OP_PUT_AT, NEWLINE_CODE, 8'h34, 5'd3, 7'd5));
        send_request(make_request(OP_PUT_AT, 8'h61,  8'h07,  5'd25, 7'd0));
        send_request(make_request(OP_PUT_AT, 8'h62,  8'h07,  5'd31, 7'd127));
        send_request(make_request(OP_PUT_AT, 8'h63,  8'h07,  5'd0,  7'd80));
        send_request(make_request(OP_READ,   8'hff,  8'hff,  5'd31, 7'd127));
        send_request(make_request(OP_PUT_AT, 8'd0,   8'h01,  5'd0,  7'd0));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd0,  7'd0));
        send_request(make_request(OP_PUT,    8'h55,  8'haa,  5'd0,  7'd0));
        send_request(make_request(OP_CLEAR,  8'hff,  8'hff,  5'd31, 7'd127));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd23, 7'd79));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd24, 7'd0));
        send_request(make_request(OP_PUT,    8'h78,  8'd0,   5'd0,  7'd0));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd0,  7'd0));
        send_request(make_request(OP_PUT_AT, 8'h79,  8'h80,  5'd24, 7'd78));
        send_request(make_request(OP_PUT,    8'h7a,  8'h80,  5'd0,  7'd0));
        send_request(make_request(OP_READ,   8'd0,   8'd0,   5'd23, 7'd78));
        send_request(make_request(OP_PUT_AT, NEWLINE_CODE, 8'd0, 5'd12, 7'd40));
        wait_drained();

        run_phase(440, 0,  0,  8'hff, 60, 200);
        run_phase(440, 63, 0,  8'($urandom_range(1, 254)), -1, -1);
        run_phase(440, 0,  63, 8'($urandom_range(1, 254)), -1, -1);
        run_phase(440, 35, 35, 8'd0, -1, -1);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0 && results_pending == 0) begin
            $display("text_console_writer_tb OK");
        end else begin
            $display("text_console_writer_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("text_console_writer_tb NOT OK");
        $finish;
    end

endmodule
